// ===== src/row_to_page_bit_transpose_defines.svh =====
// assertion macros for the row to page bit transpose block
`ifndef ROW_TO_PAGE_BIT_TRANSPOSE_DEFINES_SVH
`define ROW_TO_PAGE_BIT_TRANSPOSE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define RTPT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define RTPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rtpt_pkg.sv =====
// shared types, constants and the 8x8 bit transpose for the row to page block
package rtpt_pkg;

  localparam int BYTES_PER_ROW = 16;
  localparam int STORE_ROWS    = 7;
  localparam int CHAIN_LEN     = 8;
  localparam int COL_W         = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [2:0]       row_t;
  typedef logic [7:0]       byte_t;
  typedef logic [STORE_ROWS-1:0][7:0] store_rows_t;
  typedef logic [CHAIN_LEN-1:0][7:0]  block_t;

  localparam row_t ROW_LAST = 3'd7;
  localparam col_t COL_LAST = COL_W'(BYTES_PER_ROW - 1);

  // one cell of the output chain
  typedef struct packed {
    logic  valid;
    logic  last;
    byte_t data;
  } cell_t;

  localparam cell_t CELL_EMPTY = '0;

  // output byte i holds bit (7-i) of every page row, row j at bit j
  function automatic block_t transpose(input block_t rows);
    block_t cols;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        cols[i][j] = rows[j][7-i];
      end
    end
    return cols;
  endfunction

endpackage

// ===== src/row_to_page_bit_transpose.sv =====
// top level: row counters, row store read stage and the eight-cell output chain
// Pixel bytes of rows zero to six of each page are taken one per cycle and
// written into the row store; they give no output. The byte of row seven reads
// its column back from the store (a registered read), the 8x8 bit block is
// transposed and loaded into a chain of eight cells that hands one vertical
// byte per cycle to the output while the output is not stalled, the eighth
// flagged as last. A row seven item is registered with its column read and
// waits as pending until the chain is free; the next row seven item can be
// taken while the chain still drains, but stalls while one is pending. The
// store read overlaps the draining of the previous column.
// No clearing pass follows reset.
`include "row_to_page_bit_transpose_defines.svh"

module row_to_page_bit_transpose (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rtpt_pkg::byte_t pixel_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output rtpt_pkg::byte_t vertical_byte,
  output logic            last_of_group
);
  import rtpt_pkg::*;

  row_t        row;
  col_t        col;
  logic        pend;
  byte_t       px_q;
  store_rows_t rd_rows;
  logic        in_acc;
  logic        out_acc;
  logic        is_last_row;
  logic        chain_load;
  block_t      rows_all;
  block_t      cols_all;
  cell_t       load_cells [CHAIN_LEN];
  cell_t       cells      [CHAIN_LEN];
  logic [CHAIN_LEN-1:0] cell_v;

  // input handshake: row seven waits while a block is queued for the chain
  assign is_last_row = (row == ROW_LAST);
  assign in_stall    = is_last_row && pend;
  assign in_acc      = in_valid && !in_stall;

  // row and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (in_acc) begin
      if (col == COL_LAST) begin
        col <= '0;
        row <= row + 3'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  rtpt_store u_store (
    .clk     (clk),
    .wr_en   (in_acc && !is_last_row),
    .rd_en   (in_acc && is_last_row),
    .col     (col),
    .row     (row),
    .wr_data (pixel_byte),
    .rd_rows (rd_rows)
  );

  // pending block: last-row byte waits with its column read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (in_acc && is_last_row) begin
      pend <= 1'b1;
    end else if (chain_load) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_last_row) begin
      px_q <= pixel_byte;
    end
  end

  // transpose the block for the chain
  assign rows_all = {px_q, rd_rows};
  assign cols_all = transpose(rows_all);

  // chain is free when empty or when its final item leaves now
  assign out_acc    = out_valid && !out_stall;
  assign chain_load = pend && (!cell_v[0] || (out_acc && !cell_v[1]));

  // output chain
  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
    assign load_cells[k] = '{valid: 1'b1, last: (k == CHAIN_LEN - 1), data: cols_all[k]};
    assign cell_v[k]     = cells[k].valid;

    rtpt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (chain_load),
      .shift     (out_acc),
      .load_cell (load_cells[k]),
      .next_cell ((k == CHAIN_LEN - 1) ? CELL_EMPTY : cells[(k + 1) % CHAIN_LEN]),
      .slot      (cells[k])
    );
  end

  assign out_valid     = cells[0].valid;
  assign vertical_byte = cells[0].data;
  assign last_of_group = cells[0].last;

  // valid cells always form an unbroken run from the output end
  `RTPT_ASSERT(a_chain_packed, ((cell_v & (cell_v + 8'd1)) == 8'd0), "chain has a gap")
  // the flagged byte is the final one left in the chain
  `RTPT_ASSERT(a_last_at_end, (!(out_valid && last_of_group) || !cell_v[1]), "last not at end")
  // a load fills the whole chain
  `RTPT_ASSERT_NEXT(a_load_full, chain_load, (cell_v == 8'hFF && cells[CHAIN_LEN-1].last), "partial load")
  // a last-row item always queues a block
  `RTPT_ASSERT_NEXT(a_row7_pend, (in_acc && is_last_row), pend, "block not queued")

endmodule

// ===== src/rtpt_store.sv =====
// row store: one wide entry per byte column, one byte lane per page row
module rtpt_store (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic                 rd_en,
  input  rtpt_pkg::col_t       col,
  input  rtpt_pkg::row_t       row,
  input  rtpt_pkg::byte_t      wr_data,
  output rtpt_pkg::store_rows_t rd_rows
);
  import rtpt_pkg::*;

  store_rows_t mem [BYTES_PER_ROW];

  // byte lane write for rows zero to six
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col][row] <= wr_data;
    end
  end

  // registered read of a whole column
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rows <= mem[col];
    end
  end

endmodule

// ===== src/rtpt_cell.sv =====
// one cell of the output chain: loads in parallel, shifts toward the output
module rtpt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          shift,
  input  rtpt_pkg::cell_t load_cell,
  input  rtpt_pkg::cell_t next_cell,
  output rtpt_pkg::cell_t slot
);
  import rtpt_pkg::*;

  // parallel load wins over shift
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (load) begin
      slot <= load_cell;
    end else if (shift) begin
      slot <= next_cell;
    end
  end

endmodule

// ===== dv/tb_row_to_page_bit_transpose.sv =====
// testbench for the row to page bit transpose: random pixel stream, page byte prediction, checks
module tb_row_to_page_bit_transpose;
  import rtpt_pkg::*;

  localparam int RANDOM_ITEMS = 414;
  localparam int HOLD_OFF     = 60;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 24;

  // one pixel byte waiting to be sent, with its lead-in gap
  typedef struct {
    byte_t       px;
    int unsigned gap;
    bit          drain_first;
  } feed_item_t;

  // one vertical byte as the block should send it
  typedef struct packed {
    byte_t data;
    logic  last;
  } page_byte_t;

  logic  clk           = 1'b0;
  logic  rst           = 1'b1;
  logic  in_valid      = 1'b0;
  byte_t pixel_byte    = '0;
  logic  out_stall     = 1'b0;
  logic  in_stall;
  logic  out_valid;
  byte_t vertical_byte;
  logic  last_of_group;

  feed_item_t  pixel_feed [$];
  page_byte_t  vertical_due [$];

  // own copy of the page rows and counters
  byte_t page_rows [STORE_ROWS][BYTES_PER_ROW];
  row_t  row_cnt = '0;
  col_t  col_cnt = '0;

  int unsigned tx_wait        = 0;
  int unsigned rx_wait        = 0;
  int unsigned results_seen   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned mismatch_count = 0;

  byte_t corner_bytes [16] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                               8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F, 8'hFE};

  row_to_page_bit_transpose uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_byte    (pixel_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .vertical_byte (vertical_byte),
    .last_of_group (last_of_group)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatch_count++;
  endtask

  // store rows 0..6, on row 7 turn the column block into eight vertical bytes
  task automatic predict_vertical(input byte_t px);
    byte_t      rows [8];
    byte_t      v;
    page_byte_t pb;
    if (row_cnt != ROW_LAST) begin
      page_rows[row_cnt][col_cnt] = px;
    end else begin
      for (int j = 0; j < STORE_ROWS; j++) rows[j] = page_rows[j][col_cnt];
      rows[7] = px;
      for (int i = 0; i < 8; i++) begin
        for (int j = 0; j < 8; j++) v[j] = rows[j][7-i];
        pb.data = v;
        pb.last = (i == 7);
        vertical_due.push_back(pb);
      end
    end
    if (col_cnt == COL_LAST) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
  endtask

  // driver: offers queued pixel bytes, predicts on every accepted item
  always @(posedge clk) begin : driver
    logic  nxt_valid;
    byte_t nxt_px;
    feed_item_t it;
    nxt_valid = in_valid;
    nxt_px    = pixel_byte;
    if (rst) begin
      nxt_valid = 1'b0;
      nxt_px    = '0;
      tx_wait   = 0;
      row_cnt   = '0;
      col_cnt   = '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_vertical(pixel_byte);
        nxt_valid = 1'b0;
        if (pixel_feed.size() != 0) tx_wait = pixel_feed[0].gap;
      end else if (!in_valid && tx_wait != 0) begin
        tx_wait--;
      end
      // a drain item holds back until every expected byte has come out
      if (!nxt_valid && tx_wait == 0 && pixel_feed.size() != 0 &&
          !(pixel_feed[0].drain_first && vertical_due.size() != 0)) begin
        it        = pixel_feed.pop_front();
        nxt_valid = 1'b1;
        nxt_px    = it.px;
      end
    end
    in_valid   <= nxt_valid;
    pixel_byte <= nxt_px;
  end

  // monitor: checks each accepted vertical byte and draws the next stall
  always @(posedge clk) begin : monitor
    page_byte_t  pb;
    int unsigned gap;
    if (rst) begin
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (vertical_due.size() == 0) begin
          report_mismatch($sformatf("unexpected vertical byte %02h", vertical_byte));
        end else begin
          pb = vertical_due.pop_front();
          if (vertical_byte !== pb.data)
            report_mismatch($sformatf("vertical_byte %02h, expected %02h",
                                      vertical_byte, pb.data));
          if (last_of_group !== pb.last)
            report_mismatch($sformatf("last_of_group %b, expected %b",
                                      last_of_group, pb.last));
        end
        results_seen++;
        // long hold-off lets the block back up into its input
        if (results_seen == 24 || results_seen == 200 || results_seen == 330)
          gap = HOLD_OFF;
        else if ((results_seen / 50) % 4 == 3)
          gap = 0;
        else
          gap = $urandom_range(0, 4);
        rx_wait = gap;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
    end
    out_stall <= (rx_wait != 0);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    feed_item_t it;
    // directed: corner patterns fill the first row
    foreach (corner_bytes[k]) begin
      it.px          = corner_bytes[k];
      it.gap         = $urandom_range(0, 4);
      it.drain_first = 1'b0;
      pixel_feed.push_back(it);
    end
    // random: mostly random bytes, some corner patterns, bands with no gaps
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 3) == 0)
        it.px = corner_bytes[$urandom_range(0, 15)];
      else
        it.px = byte_t'($urandom_range(0, 255));
      it.gap         = ((k / 40) % 4 == 2) ? 0 : $urandom_range(0, 4);
      it.drain_first = (k == 0 || k == 180 || k == 300);
      pixel_feed.push_back(it);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pixel_feed.size() != 0 || in_valid || vertical_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
